>>> hdl/cgms_pkg.sv
// Package for the compressed gadget matrix store.
// Holds the sizes, the row tables and the decode result type.
// Used by the address decode, the top level and the testbench; depends on nothing.
package cgms_pkg;

    localparam int POOL_DEPTH   = 768;
    localparam int DIGITS       = 3;
    localparam int POOL_AW      = $clog2(POOL_DEPTH);
    localparam int PACKED_ROWS  = 24;
    localparam int ROW_W        = 5;
    localparam int COL_W        = 9;
    localparam int VALUE_W      = 64;
    localparam int COEFF_W      = 16;
    localparam int TDATA_IN_W   = 80;
    localparam int BASE_SEL_W   = 2;
    localparam int SHIFT_W      = 3;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [VALUE_W-1:0] GADGET_ONE  = 64'd1;
    localparam logic [VALUE_W-1:0] GADGET_MID  = 64'd32768;
    localparam logic [VALUE_W-1:0] GADGET_HIGH = 64'd1073741824;

    typedef logic [POOL_AW-1:0] offset_tab_t [PACKED_ROWS];
    typedef logic [SHIFT_W-1:0] shift_tab_t [PACKED_ROWS];
    typedef logic [VALUE_W-1:0] gadget_tab_t [PACKED_ROWS];

    localparam offset_tab_t ROW_OFFSET = '{
        POOL_AW'(0),   POOL_AW'(1),   POOL_AW'(2),   POOL_AW'(3),
        POOL_AW'(5),   POOL_AW'(7),   POOL_AW'(9),   POOL_AW'(13),
        POOL_AW'(17),  POOL_AW'(21),  POOL_AW'(29),  POOL_AW'(37),
        POOL_AW'(45),  POOL_AW'(61),  POOL_AW'(77),  POOL_AW'(93),
        POOL_AW'(125), POOL_AW'(157), POOL_AW'(189), POOL_AW'(253),
        POOL_AW'(317), POOL_AW'(381), POOL_AW'(509), POOL_AW'(637)
    };

    // Stride of row r is 128 >> (r / 3), kept as its base-two logarithm.
    function automatic shift_tab_t build_shift_tab();
        shift_tab_t tab;
        for (int i = 0; i < PACKED_ROWS; i++)
        begin
            tab[i] = SHIFT_W'(7 - i / 3);
        end
        return tab;
    endfunction

    function automatic gadget_tab_t build_gadget_tab();
        gadget_tab_t tab;
        for (int i = 0; i < PACKED_ROWS; i++)
        begin
            case (i % DIGITS)
                0:       tab[i] = GADGET_ONE;
                1:       tab[i] = GADGET_MID;
                2:       tab[i] = GADGET_HIGH;
                default: tab[i] = '0;
            endcase
        end
        return tab;
    endfunction

    localparam shift_tab_t  ROW_SHIFT  = build_shift_tab();
    localparam gadget_tab_t GADGET_TAB = build_gadget_tab();

    typedef struct packed {
        logic                  pool_hit;
        logic [POOL_AW-1:0]    slot_addr;
        logic                  base_hit;
        logic [BASE_SEL_W-1:0] base_sel;
        logic [VALUE_W-1:0]    const_value;
    } decode_t;

endpackage

>>> hdl/cgms_addr_decode.sv
// Address decode for the compressed gadget matrix store.
// Maps (row, column) to a pool slot, a base register or a fixed gadget power.
// Depends on cgms_pkg.
module cgms_addr_decode (
    input  logic [cgms_pkg::ROW_W-1:0] row,
    input  logic [cgms_pkg::COL_W-1:0] col,
    output cgms_pkg::decode_t          dec
);
    import cgms_pkg::*;

    logic [SHIFT_W-1:0] shift;
    logic [7:0]         col_low;
    logic [7:0]         low_mask;
    logic [7:0]         slot_off;
    logic [POOL_AW:0]   idx_sum;
    logic               packed_row;
    logic               col_zero;
    logic               odd_multiple;

    assign packed_row = (row < ROW_W'(PACKED_ROWS));
    assign col_zero   = (col == '0);
    assign col_low    = col[7:0];
    assign shift      = packed_row ? ROW_SHIFT[row] : '0;
    assign low_mask   = (8'd1 << shift) - 8'd1;
    assign odd_multiple = !col[8] && ((col_low & low_mask) == 8'd0) && col_low[shift];
    assign slot_off   = {1'b0, col_low[7:1]} >> shift;
    assign idx_sum    = {1'b0, (packed_row ? ROW_OFFSET[row] : POOL_AW'(0))}
                        + (POOL_AW + 1)'(slot_off);

    always_comb
    begin
        dec.pool_hit    = packed_row && odd_multiple
                          && (idx_sum < (POOL_AW + 1)'(POOL_DEPTH));
        dec.slot_addr   = idx_sum[POOL_AW-1:0];
        dec.base_hit    = (row[4:2] == 3'b110) && col_zero;
        dec.base_sel    = row[1:0];
        dec.const_value = (packed_row && col_zero) ? GADGET_TAB[row] : '0;
    end

endmodule

>>> hdl/cgms_pool_ram.sv
// Single-port synchronous RAM holding the packed coefficient pool.
// One write or one registered read per cycle; no dependencies.
module cgms_pool_ram #(
    parameter int DEPTH = 768,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/compressed_gadget_matrix_store_core.sv
// Top level of the compressed gadget matrix store.
//
//   Channel  Direction  Transfer contents
//   s_*      in         tuser: command; tdata: row, col, write_value
//   m_*      out        tuser: stored; tdata: read_value
//
// One transfer is taken per cycle while s_tready is high; its result leaves through
// a registered pool read and an output register. After reset the pool is swept to
// zero, one word per cycle, and s_tready stays low until all POOL_DEPTH (768) words
// are clear. A stalled output holds the pipeline and drops s_tready once stage one is full.
// Depends on cgms_pkg, cgms_addr_decode and cgms_pool_ram.
module compressed_gadget_matrix_store_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cgms_pkg::TDATA_IN_W-1:0] s_tdata,   // row, col, write_value
    input  logic                           s_tuser,    // command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cgms_pkg::VALUE_W-1:0]   m_tdata,    // read_value
    output logic                           m_tuser     // stored
);
    import cgms_pkg::*;

    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [VALUE_W-1:0] write_value;
    logic               command;
    decode_t            dec;

    logic               clearing_reg;
    logic [POOL_AW-1:0] clear_cnt_reg;

    logic               st1_valid_reg;
    logic               st1_use_mem_reg;
    logic               st1_stored_reg;
    logic [VALUE_W-1:0] st1_value_reg;

    logic               out_valid_reg;
    logic               out_stored_reg;
    logic [VALUE_W-1:0] out_value_reg;

    logic [VALUE_W-1:0] base_reg [4];

    logic               advance;
    logic               accept;
    logic               is_write;
    logic               ram_we;
    logic               ram_re;
    logic [POOL_AW-1:0] ram_addr;
    logic [COEFF_W-1:0] ram_wdata;
    logic [COEFF_W-1:0] ram_rdata;
    logic [VALUE_W-1:0] st1_result;

    assign row         = s_tdata[ROW_W-1:0];
    assign col         = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign write_value = s_tdata[ROW_W+COL_W+VALUE_W-1:ROW_W+COL_W];
    assign command     = s_tuser;
    assign is_write    = (command == CMD_WRITE);

    cgms_addr_decode u_decode (
        .row (row),
        .col (col),
        .dec (dec)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !clearing_reg && (!st1_valid_reg || advance);
    assign accept   = s_tvalid && s_tready;

    assign ram_we    = clearing_reg || (accept && is_write && dec.pool_hit);
    assign ram_re    = accept && !is_write && dec.pool_hit;
    assign ram_addr  = clearing_reg ? clear_cnt_reg : dec.slot_addr;
    assign ram_wdata = clearing_reg ? '0 : write_value[COEFF_W-1:0];

    cgms_pool_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (COEFF_W)
    ) u_pool_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + POOL_AW'(1);
            if (clear_cnt_reg == POOL_AW'(POOL_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                base_reg[i] <= '0;
            end
        end
        else if (accept && is_write && dec.base_hit)
        begin
            base_reg[dec.base_sel] <= write_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            st1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st1_use_mem_reg <= !is_write && dec.pool_hit;
            st1_stored_reg  <= is_write && (dec.pool_hit || dec.base_hit);
            if (is_write)
            begin
                st1_value_reg <= '0;
            end
            else if (dec.base_hit)
            begin
                st1_value_reg <= base_reg[dec.base_sel];
            end
            else
            begin
                st1_value_reg <= dec.const_value;
            end
        end
    end

    assign st1_result = st1_use_mem_reg
                        ? {{(VALUE_W - COEFF_W){ram_rdata[COEFF_W-1]}}, ram_rdata}
                        : st1_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && st1_valid_reg)
        begin
            out_value_reg  <= st1_result;
            out_stored_reg <= st1_stored_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_stored_reg;

endmodule

>>> tb/sv/tb_compressed_gadget_matrix_store_core.sv
// Testbench for compressed_gadget_matrix_store_core: directed and random reads and writes
// checked against an in-bench model of the packed pool and the base-value rows.
// Depends on cgms_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_compressed_gadget_matrix_store_core;
    import cgms_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               stored;
    } entry_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata = '0;
    logic                   s_tuser = CMD_READ;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [VALUE_W-1:0]     m_tdata;
    logic                   m_tuser;

    logic [COEFF_W-1:0]     model_pool [POOL_DEPTH];
    logic [VALUE_W-1:0]     model_base [4];
    entry_result_t          awaited_results [$];

    int  fail_count = 0;
    int  cycle_count = 0;
    int  read_count = 0;
    int  write_count = 0;
    int  landed_count = 0;
    int  checked_count = 0;
    int  sink_hold_cycles = 0;
    bit  sender_gaps_on = 1'b1;
    bit  sink_stalls_on = 1'b1;

    compressed_gadget_matrix_store_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles with %0d results outstanding",
                         cycle_count, awaited_results.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Pool word of a packed-row entry, or -1 when the entry is not kept.
    function automatic int coeff_slot(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        int group;
        int stride;
        int mult;
        int first;
        if (row >= PACKED_ROWS || col == 0 || col >= 256)
            return -1;
        group = row / 3;
        stride = 128 >> group;
        if (col % stride != 0)
            return -1;
        mult = col / stride;
        if (mult % 2 == 0)
            return -1;
        first = 0;
        for (int r = 0; r < row; r++)
        begin
            first += 1 << (r / 3);
        end
        if (first + (mult - 1) / 2 >= POOL_DEPTH)
            return -1;
        return first + (mult - 1) / 2;
    endfunction

    function automatic entry_result_t apply_access(input logic cmd, input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [VALUE_W-1:0] value);
        entry_result_t res;
        int slot;
        res = '0;
        if (row >= PACKED_ROWS)
        begin
            if (row < PACKED_ROWS + 4 && col == 0)
            begin
                if (cmd == CMD_WRITE)
                begin
                    model_base[row - PACKED_ROWS] = value;
                    res.stored = 1'b1;
                end
                else
                begin
                    res.value = model_base[row - PACKED_ROWS];
                end
            end
        end
        else if (col == 0)
        begin
            if (cmd == CMD_READ)
            begin
                case (row % DIGITS)
                    0:       res.value = GADGET_ONE;
                    1:       res.value = GADGET_MID;
                    2:       res.value = GADGET_HIGH;
                    default: res.value = '0;
                endcase
            end
        end
        else
        begin
            slot = coeff_slot(row, col);
            if (slot >= 0)
            begin
                if (cmd == CMD_WRITE)
                begin
                    model_pool[slot] = value[COEFF_W-1:0];
                    res.stored = 1'b1;
                end
                else
                begin
                    res.value = {{(VALUE_W-COEFF_W){model_pool[slot][COEFF_W-1]}},
                                 model_pool[slot]};
                end
            end
        end
        return res;
    endfunction

    // Called at a rising edge; returns at the edge where the transfer is taken.
    task automatic send_access(input logic cmd, input logic [ROW_W-1:0] row,
                               input logic [COL_W-1:0] col, input logic [VALUE_W-1:0] value);
        entry_result_t res;
        if (sender_gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, value, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        res = apply_access(cmd, row, col, value);
        awaited_results.push_back(res);
        if (cmd == CMD_WRITE)
            write_count++;
        else
            read_count++;
        if (res.stored)
            landed_count++;
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                sink_hold_cycles--;
            end
            else if (sink_stalls_on && stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (sink_stalls_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 4) - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        entry_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result value=%h stored=%b",
                                              m_tdata, m_tuser));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    checked_count++;
                    if (m_tdata !== want.value)
                        report_mismatch($sformatf("read_value got %h expected %h",
                                                  m_tdata, want.value));
                    if (m_tuser !== want.stored)
                        report_mismatch($sformatf("stored got %b expected %b",
                                                  m_tuser, want.stored));
                end
            end
        end
    end

    task automatic test_gadget_column();
        send_access(CMD_READ, 5'd0, 9'd0, '0);
        send_access(CMD_READ, 5'd1, 9'd0, '0);
        send_access(CMD_READ, 5'd23, 9'd0, '1);
        send_access(CMD_WRITE, 5'd0, 9'd0, 64'h0123_4567_89ab_cdef);
        send_access(CMD_READ, 5'd0, 9'd0, '0);
    endtask

    task automatic test_base_rows();
        send_access(CMD_WRITE, 5'd24, 9'd0, 64'h8000_0000_0000_0000);
        send_access(CMD_READ, 5'd24, 9'd0, '0);
        send_access(CMD_WRITE, 5'd27, 9'd0, '1);
        send_access(CMD_READ, 5'd27, 9'd0, '0);
        send_access(CMD_WRITE, 5'd25, 9'd1, 64'h7fff_ffff_ffff_ffff);
        send_access(CMD_READ, 5'd25, 9'd0, '0);
    endtask

    task automatic test_packed_extremes();
        send_access(CMD_WRITE, 5'd0, 9'd128, 64'h0000_0000_0000_8000);
        send_access(CMD_READ, 5'd0, 9'd128, '0);
        send_access(CMD_WRITE, 5'd23, 9'd255, 64'h7fff_ffff_ffff_ffff);
        send_access(CMD_READ, 5'd23, 9'd255, '0);
        send_access(CMD_WRITE, 5'd22, 9'd1, 64'hffff_ffff_ffff_7fff);
        send_access(CMD_READ, 5'd22, 9'd1, '0);
    endtask

    task automatic test_dropped_accesses();
        send_access(CMD_WRITE, 5'd5, 9'd128, '1);
        send_access(CMD_WRITE, 5'd0, 9'd384, '1);
        send_access(CMD_READ, 5'd0, 9'd384, '0);
        send_access(CMD_WRITE, 5'd31, 9'd0, '1);
        send_access(CMD_READ, 5'd29, 9'd0, '0);
        send_access(CMD_READ, 5'd30, 9'd511, '0);
    endtask

    task automatic random_access();
        int kind;
        int group;
        logic cmd;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VALUE_W-1:0] value;
        kind = $urandom_range(0, 99);
        cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        value = {$urandom, $urandom};
        if (kind < 65)
        begin
            row = ROW_W'($urandom_range(0, PACKED_ROWS - 1));
            group = row / 3;
            col = COL_W'((2 * $urandom_range(0, (1 << group) - 1) + 1) * (128 >> group));
        end
        else if (kind < 80)
        begin
            row = ROW_W'($urandom_range(PACKED_ROWS, PACKED_ROWS + 3));
            col = '0;
        end
        else if (kind < 86)
        begin
            row = ROW_W'($urandom_range(0, PACKED_ROWS - 1));
            col = '0;
        end
        else
        begin
            row = ROW_W'($urandom);
            col = COL_W'($urandom);
        end
        send_access(cmd, row, col, value);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) random_access();
    endtask

    // The sink holds off long enough for the pipeline to fill and stall the input.
    task automatic test_backpressure();
        bit gaps_saved;
        gaps_saved = sender_gaps_on;
        sender_gaps_on = 1'b0;
        sink_hold_cycles = 60;
        repeat (30) random_access();
        sender_gaps_on = gaps_saved;
    endtask

    task automatic test_full_rate();
        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        repeat (150) random_access();
    endtask

    initial
    begin
        foreach (model_pool[i])
            model_pool[i] = '0;
        foreach (model_base[i])
            model_base[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_gadget_column();
        test_base_rows();
        test_packed_extremes();
        test_dropped_accesses();
        test_random_traffic(220);
        test_backpressure();
        test_random_traffic(200);
        test_full_rate();

        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d reads and %0d writes (%0d landed), %0d results checked.",
                 read_count, write_count, landed_count, checked_count);
        $display("Gadget column, base rows, pool extremes, dropped entries and a long stall.");
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/cgms_pkg.sv
hdl/cgms_addr_decode.sv
hdl/cgms_pool_ram.sv
hdl/compressed_gadget_matrix_store_core.sv
tb/sv/tb_compressed_gadget_matrix_store_core.sv
